// ===== src/targa_rle_packet_encoder_defines.svh =====
// Assertion macros shared by the TGA run-length packet encoder RTL.
`ifndef TARGA_RLE_PACKET_ENCODER_DEFINES_SVH
`define TARGA_RLE_PACKET_ENCODER_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, quiet while rst_ni is low.
`define TRLE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, quiet while rst_ni is low.
`define TRLE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/trle_pkg.sv =====
// Shared constants, types and helper functions of the TGA run-length packet encoder.
`default_nettype none

package trle_pkg;

  localparam int unsigned MAX_PACKET_PIXELS   = 128;
  localparam int unsigned MAX_BYTES_PER_PIXEL = 4;

  localparam int unsigned PX_W        = 32;
  localparam int unsigned BPP_W       = 3;
  localparam int unsigned HDR_W       = 8;
  localparam int unsigned NPIX_W      = 3;
  localparam int unsigned PX_PER_ITEM = 4;
  localparam int unsigned LANE_W      = 2;
  localparam int unsigned CNT_W       = $clog2(MAX_PACKET_PIXELS + 1);
  localparam int unsigned ROWS        = (MAX_PACKET_PIXELS + PX_PER_ITEM - 1) / PX_PER_ITEM;
  localparam int unsigned ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef logic [PX_W-1:0]   px_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [LANE_W-1:0] lane_t;

  localparam logic [BPP_W-1:0] BPP_RESET       = 3'd4;
  localparam logic [HDR_W-1:0] REPEAT_FLAG     = 8'h80;
  localparam cnt_t             RUN_START_COUNT = cnt_t'(2);
  // A fresh run already fills a packet when packets hold only two pixels.
  localparam logic             RUN_START_FULL  = (MAX_PACKET_PIXELS <= 2);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_PEND,
    MODE_RUN
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REP,
    ST_WR_X,
    ST_FL_START,
    ST_FL_LD
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic take_px;     // latch incoming pixel as lookahead
    logic run_start;   // open repeat run from lookahead pixel
    logic run_inc;     // extend repeat run
    logic raw_wr;      // append lookahead pixel to raw buffer
    logic rd_first;    // read first buffer row
    logic rd_next;     // read following buffer row
    logic load_raw;    // load raw packet beat into output register
    logic load_rep;    // load repeat packet beat into output register
    logic final_item;  // beat closes the burst of this pixel
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic eq_pend;
    logic eq_rep;
    logic raw_empty;
    logic raw_almost_full;
    logic raw_full;
    logic run_almost_max;
    logic grp_last;
    logic out_free;
  } sts_t;

  // Byte mask of the active pixel bytes; out-of-range counts are clamped.
  function automatic px_t active_mask(input logic [BPP_W-1:0] bpp);
    int unsigned eff;
    px_t         m;
    eff = 32'(bpp);
    if (eff == 0) begin
      eff = 1;
    end
    if (eff > MAX_BYTES_PER_PIXEL) begin
      eff = MAX_BYTES_PER_PIXEL;
    end
    for (int i = 0; i < PX_W / 8; i++) begin
      m[i*8 +: 8] = (32'(i) < eff) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // Pixel count minus one, as the seven low header bits.
  function automatic logic [HDR_W-2:0] hdr_count(input cnt_t cnt);
    cnt_t d;
    d = cnt - cnt_t'(1);
    return (HDR_W-1)'(d);
  endfunction

endpackage

`default_nettype wire

// ===== src/trle_ifs.sv =====
// Valid/ready channel interfaces for pixel input and packet output beats.
`default_nettype none

interface trle_pix_if;
  logic                     valid;
  logic                     ready;
  logic [trle_pkg::PX_W-1:0] pixel_value;
  logic                     last_pixel;

  modport source (output valid, pixel_value, last_pixel, input ready);
  modport sink   (input valid, pixel_value, last_pixel, output ready);
endinterface

interface trle_pkt_if;
  logic                         valid;
  logic                         ready;
  logic                         header_present;
  logic [trle_pkg::HDR_W-1:0]   header_byte;
  logic [trle_pkg::NPIX_W-1:0]  pixels_in_item;
  logic [2*trle_pkg::PX_W-1:0]  pixel_pair_first;
  logic [2*trle_pkg::PX_W-1:0]  pixel_pair_second;
  logic                         final_of_burst;

  modport source (output valid, header_present, header_byte, pixels_in_item,
                  pixel_pair_first, pixel_pair_second, final_of_burst, input ready);
  modport sink   (input valid, header_present, header_byte, pixels_in_item,
                  pixel_pair_first, pixel_pair_second, final_of_burst, output ready);
endinterface

`default_nettype wire

// ===== src/trle_dp.sv =====
// Datapath: lookahead and run registers, raw pixel buffer and output beat register.
`default_nettype none

module trle_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [trle_pkg::BPP_W-1:0]  cfg_wdata_i,
  input  trle_pkg::px_t               px_i,
  input  trle_pkg::cmd_t              cmd_i,
  output trle_pkg::sts_t              sts_o,
  trle_pkt_if.source                  pkt_o
);

  logic [trle_pkg::BPP_W-1:0] bpp_q;
  trle_pkg::px_t              mask;

  trle_pkg::cnt_t  raw_cnt_q;
  trle_pkg::cnt_t  rep_cnt_q;
  trle_pkg::cnt_t  rem;
  trle_pkg::row_t  grp_q;
  trle_pkg::row_t  rd_row;
  trle_pkg::row_t  wr_row;
  trle_pkg::lane_t wr_lane;
  trle_pkg::px_t   pend_q;
  trle_pkg::px_t   rep_px_q;
  logic            rd_en;
  logic            grp_last;
  logic            out_free;
  logic            load;

  trle_pkg::px_t raw_mem_q [trle_pkg::PX_PER_ITEM][trle_pkg::ROWS];
  trle_pkg::px_t rd_q      [trle_pkg::PX_PER_ITEM];

  logic                        out_vld_q;
  logic                        out_hdr_vld_q, out_hdr_vld_d;
  logic [trle_pkg::HDR_W-1:0]  out_hdr_q, out_hdr_d;
  logic [trle_pkg::NPIX_W-1:0] out_n_q, out_n_d;
  logic                        out_fin_q;
  trle_pkg::px_t               out_px_q [trle_pkg::PX_PER_ITEM];
  trle_pkg::px_t               out_px_d [trle_pkg::PX_PER_ITEM];

  assign mask = trle_pkg::active_mask(bpp_q);

  // Pixels still to send from the current row onwards.
  assign rem      = raw_cnt_q - trle_pkg::cnt_t'({grp_q, 2'b00});
  assign grp_last = (rem <= trle_pkg::cnt_t'(trle_pkg::PX_PER_ITEM));

  assign wr_lane  = raw_cnt_q[trle_pkg::LANE_W-1:0];
  assign wr_row   = trle_pkg::row_t'(raw_cnt_q >> trle_pkg::LANE_W);
  assign rd_en    = cmd_i.rd_first | cmd_i.rd_next;
  assign rd_row   = cmd_i.rd_first ? '0 : grp_q + trle_pkg::row_t'(1);

  assign out_free = !out_vld_q || pkt_o.ready;
  assign load     = cmd_i.load_raw | cmd_i.load_rep;

  assign sts_o.eq_pend         = ((px_i ^ pend_q) & mask) == '0;
  assign sts_o.eq_rep          = ((px_i ^ rep_px_q) & mask) == '0;
  assign sts_o.raw_empty       = (raw_cnt_q == '0);
  assign sts_o.raw_almost_full =
    (raw_cnt_q == trle_pkg::cnt_t'(trle_pkg::MAX_PACKET_PIXELS - 1));
  assign sts_o.raw_full        = (raw_cnt_q == trle_pkg::cnt_t'(trle_pkg::MAX_PACKET_PIXELS));
  assign sts_o.run_almost_max  =
    (rep_cnt_q >= trle_pkg::cnt_t'(trle_pkg::MAX_PACKET_PIXELS - 1));
  assign sts_o.grp_last        = grp_last;
  assign sts_o.out_free        = out_free;

  // Build the next output beat: repeat packet by default, raw packet row on request.
  always_comb begin
    out_hdr_vld_d = 1'b1;
    out_hdr_d     = trle_pkg::REPEAT_FLAG | {1'b0, trle_pkg::hdr_count(rep_cnt_q)};
    out_n_d       = 3'd1;
    for (int k = 0; k < trle_pkg::PX_PER_ITEM; k++) begin
      out_px_d[k] = '0;
    end
    out_px_d[0] = rep_px_q & mask;
    if (cmd_i.load_raw) begin
      out_hdr_vld_d = (grp_q == '0);
      out_hdr_d     = (grp_q == '0) ? {1'b0, trle_pkg::hdr_count(raw_cnt_q)} : '0;
      out_n_d       = grp_last ? trle_pkg::NPIX_W'(rem) : trle_pkg::NPIX_W'(trle_pkg::PX_PER_ITEM);
      for (int k = 0; k < trle_pkg::PX_PER_ITEM; k++) begin
        out_px_d[k] = (trle_pkg::NPIX_W'(k) < out_n_d) ? (rd_q[k] & mask) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q     <= trle_pkg::BPP_RESET;
      raw_cnt_q <= '0;
      rep_cnt_q <= '0;
      grp_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bpp_q <= cfg_wdata_i;
      end
      if (cmd_i.raw_wr) begin
        raw_cnt_q <= raw_cnt_q + trle_pkg::cnt_t'(1);
      end else if (cmd_i.load_raw && grp_last) begin
        raw_cnt_q <= '0;
      end
      if (cmd_i.run_start) begin
        rep_cnt_q <= trle_pkg::RUN_START_COUNT;
      end else if (cmd_i.run_inc) begin
        rep_cnt_q <= rep_cnt_q + trle_pkg::cnt_t'(1);
      end
      if (cmd_i.rd_first) begin
        grp_q <= '0;
      end else if (cmd_i.rd_next) begin
        grp_q <= grp_q + trle_pkg::row_t'(1);
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (pkt_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers and the raw buffer: no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.run_start) begin
      rep_px_q <= pend_q;
    end
    if (cmd_i.take_px) begin
      pend_q <= px_i;
    end
    if (cmd_i.raw_wr) begin
      raw_mem_q[wr_lane][wr_row] <= pend_q;
    end
    if (rd_en) begin
      for (int k = 0; k < trle_pkg::PX_PER_ITEM; k++) begin
        rd_q[k] <= raw_mem_q[k][rd_row];
      end
    end
    if (load) begin
      out_hdr_vld_q <= out_hdr_vld_d;
      out_hdr_q     <= out_hdr_d;
      out_n_q       <= out_n_d;
      out_fin_q     <= cmd_i.final_item;
      for (int k = 0; k < trle_pkg::PX_PER_ITEM; k++) begin
        out_px_q[k] <= out_px_d[k];
      end
    end
  end

  assign pkt_o.valid             = out_vld_q;
  assign pkt_o.header_present    = out_hdr_vld_q;
  assign pkt_o.header_byte       = out_hdr_q;
  assign pkt_o.pixels_in_item    = out_n_q;
  assign pkt_o.pixel_pair_first  = {out_px_q[1], out_px_q[0]};
  assign pkt_o.pixel_pair_second = {out_px_q[3], out_px_q[2]};
  assign pkt_o.final_of_burst    = out_fin_q;

endmodule

`default_nettype wire

// ===== src/trle_ctrl.sv =====
// Controller: packet mode and the sequencer that orders writes, flushes and repeat beats.
`default_nettype none

module trle_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  input  trle_pkg::sts_t sts_i,
  output trle_pkg::cmd_t cmd_o
);

  trle_pkg::state_e state_q, state_d;
  trle_pkg::mode_e  mode_q, mode_d;
  logic             wr_x_q, wr_x_d;         // lookahead pixel still to append and flush
  logic             rep_last_q, rep_last_d; // repeat beat still to send
  logic             run_close;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= trle_pkg::ST_IDLE;
      mode_q     <= trle_pkg::MODE_IDLE;
      wr_x_q     <= 1'b0;
      rep_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      wr_x_q     <= wr_x_d;
      rep_last_q <= rep_last_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    wr_x_d     = wr_x_q;
    rep_last_d = rep_last_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    run_close  = 1'b0;
    case (state_q)
      trle_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_px = 1'b1;
          case (mode_q)
            trle_pkg::MODE_PEND: begin
              if (sts_i.eq_pend) begin
                // Open a run; pending raw pixels leave first.
                cmd_o.run_start = 1'b1;
                run_close       = in_last_i || trle_pkg::RUN_START_FULL;
                mode_d          = run_close ? trle_pkg::MODE_IDLE : trle_pkg::MODE_RUN;
                rep_last_d      = run_close;
                if (!sts_i.raw_empty) begin
                  state_d = trle_pkg::ST_FL_START;
                end else if (run_close) begin
                  state_d = trle_pkg::ST_REP;
                end
              end else begin
                cmd_o.raw_wr = 1'b1;
                mode_d       = in_last_i ? trle_pkg::MODE_IDLE : trle_pkg::MODE_PEND;
                wr_x_d       = in_last_i;
                if (sts_i.raw_almost_full) begin
                  state_d = trle_pkg::ST_FL_START;
                end else if (in_last_i) begin
                  state_d = trle_pkg::ST_WR_X;
                end
              end
            end
            trle_pkg::MODE_RUN: begin
              if (sts_i.eq_rep) begin
                cmd_o.run_inc = 1'b1;
                run_close     = in_last_i || sts_i.run_almost_max;
                mode_d        = run_close ? trle_pkg::MODE_IDLE : trle_pkg::MODE_RUN;
                rep_last_d    = run_close;
                if (run_close) begin
                  state_d = trle_pkg::ST_REP;
                end
              end else begin
                mode_d  = in_last_i ? trle_pkg::MODE_IDLE : trle_pkg::MODE_PEND;
                wr_x_d  = in_last_i;
                state_d = trle_pkg::ST_REP;
              end
            end
            default: begin
              mode_d = in_last_i ? trle_pkg::MODE_IDLE : trle_pkg::MODE_PEND;
              wr_x_d = in_last_i;
              if (in_last_i) begin
                state_d = trle_pkg::ST_WR_X;
              end
            end
          endcase
        end
      end
      trle_pkg::ST_REP: begin
        if (sts_i.out_free) begin
          cmd_o.load_rep   = 1'b1;
          cmd_o.final_item = !wr_x_q;
          rep_last_d       = 1'b0;
          state_d          = wr_x_q ? trle_pkg::ST_WR_X : trle_pkg::ST_IDLE;
        end
      end
      trle_pkg::ST_WR_X: begin
        cmd_o.raw_wr = 1'b1;
        wr_x_d       = 1'b0;
        state_d      = trle_pkg::ST_FL_START;
      end
      trle_pkg::ST_FL_START: begin
        cmd_o.rd_first = 1'b1;
        state_d        = trle_pkg::ST_FL_LD;
      end
      trle_pkg::ST_FL_LD: begin
        if (sts_i.out_free) begin
          cmd_o.load_raw = 1'b1;
          if (sts_i.grp_last) begin
            cmd_o.final_item = !wr_x_q && !rep_last_q;
            if (wr_x_q) begin
              state_d = trle_pkg::ST_WR_X;
            end else if (rep_last_q) begin
              state_d = trle_pkg::ST_REP;
            end else begin
              state_d = trle_pkg::ST_IDLE;
            end
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = trle_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/targa_rle_packet_encoder.sv =====
// TGA run-length packet encoder. Pixels arrive one per beat on pix_i, with
// the byte count (cfg_wdata_i, written while idle, reset value 4, 0 acts as 1
// and values above 4 as 4) selecting how many low bytes are compared and sent.
// One pixel is held as lookahead: a pixel equal to its successor opens a repeat
// packet (header 0x80 | count-1, one pixel) of up to 128 pixels; all other
// pixels collect in a 128-entry raw buffer sent as a raw packet (header count-1,
// then the pixels) when full, when a run opens, or on last_pixel, which flushes
// everything. Packets leave on pkt_o as beats of an optional header and up to
// four pixels; final_of_burst marks the last beat caused by an input pixel.
// Sequence: a pixel that causes no packet beat leaves the sequencer idle, so
// pix_i stays ready. A repeat beat is loaded in ST_REP. A raw flush reads the
// first buffer row in ST_FL_START, then in ST_FL_LD loads beats of up to four
// pixels, reading the next row with each, paced by the single four-lane read
// port of the raw buffer. Stalls on pkt_o hold ST_REP and ST_FL_LD until the
// output register is free; a finished beat waits in the output register while
// the next pixel is taken. The raw buffer needs no clearing after reset.
`default_nettype none
`include "targa_rle_packet_encoder_defines.svh"

module targa_rle_packet_encoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [trle_pkg::BPP_W-1:0] cfg_wdata_i,
  trle_pix_if.sink                   pix_i,
  trle_pkt_if.source                 pkt_o
);

  trle_pkg::cmd_t cmd;
  trle_pkg::sts_t sts;
  logic           in_ready;
  logic           px_take;
  logic           beat_load;
  logic           beat_final;

  // Sequencer: decides per pixel which writes, flushes and repeat beats follow.
  trle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_last_i  (pix_i.last_pixel),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign pix_i.ready = in_ready;

  // Datapath: compares, raw buffer and the output beat register.
  trle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .px_i        (pix_i.pixel_value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pkt_o       (pkt_o)
  );

  assign px_take    = pix_i.valid && pix_i.ready;
  assign beat_load  = cmd.load_raw || cmd.load_rep;
  assign beat_final = beat_load && cmd.final_item;

  // A pixel is only taken while no packet beat is being produced.
  `TRLE_ASSERT_IMP(a_no_load_on_take, px_take, !beat_load, "packet beat loaded while taking a pixel")
  // The beat that closes a burst hands control back to the input side.
  `TRLE_ASSERT_NXT(a_final_then_ready, beat_final, in_ready, "input not ready after final beat")
  // Never append to a full raw buffer.
  `TRLE_ASSERT_IMP(a_raw_no_overfill, cmd.raw_wr, !sts.raw_full, "raw buffer written while full")

endmodule

`default_nettype wire

// ===== test/tb_targa_rle_packet_encoder.sv =====
// Self-checking testbench for the TGA run-length packet encoder.
`timescale 1ns / 1ps

module tb_targa_rle_packet_encoder;
  import trle_pkg::*;

  localparam int RANDOM_PIXELS = 420;
  // Cycles to let the block settle before a register write or the end of run;
  // covers the worst pixel (full raw buffer plus last_pixel) with room to spare.
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_SHOWN = 40;

  // One packet beat as it leaves the block.
  typedef struct packed {
    logic                 hdr_valid;
    logic [HDR_W-1:0]     hdr;
    logic [NPIX_W-1:0]    npix;
    logic [2*PX_W-1:0]    lanes_lo;
    logic [2*PX_W-1:0]    lanes_hi;
    logic                 burst_end;
  } beat_t;

  typedef enum int {
    RX_OPEN,
    RX_ALTERNATE,
    RX_COIN,
    RX_BURSTY
  } rx_pattern_e;

  // Scoreboard: encodes each accepted pixel into the packet beats it must cause
  // and checks the beats leaving the block against them, oldest first.
  class rle_packet_scoreboard;
    px_t              raw_pixels[$];
    px_t              lookahead;
    mode_e            enc_mode;
    px_t              run_pixel;
    int               run_len;
    logic [BPP_W-1:0] bpp;
    beat_t            expected_beats[$];
    beat_t            burst_beats[$];
    int               errors;

    function new();
      lookahead = '0;
      enc_mode  = MODE_IDLE;
      run_pixel = '0;
      run_len   = 0;
      bpp       = BPP_RESET;
      errors    = 0;
    endfunction

    // Active pixel bytes; a count of 0 acts as 1 and anything above 4 as 4.
    function px_t lane_mask();
      int unsigned eff;
      eff = 32'(bpp);
      if (eff == 0) eff = 1;
      if (eff > MAX_BYTES_PER_PIXEL) eff = MAX_BYTES_PER_PIXEL;
      if (eff >= 4) return '1;
      return px_t'((64'd1 << (8 * eff)) - 64'd1);
    endfunction

    function void put_beat(logic hp, logic [HDR_W-1:0] hb, int cnt, px_t px[4]);
      beat_t b;
      px_t   m;
      m           = lane_mask();
      b.hdr_valid = hp;
      b.hdr       = hb;
      b.npix      = NPIX_W'(cnt);
      b.lanes_lo  = {px[1] & m, px[0] & m};
      b.lanes_hi  = {px[3] & m, px[2] & m};
      b.burst_end = 1'b0;
      burst_beats.push_back(b);
    endfunction

    // Send the raw buffer as one packet, up to four pixels per beat.
    function void flush_raw();
      px_t px[4];
      int  total;
      int  cnt;
      total = raw_pixels.size();
      for (int i = 0; i < total; i += 4) begin
        px  = '{default: '0};
        cnt = (total - i > 4) ? 4 : total - i;
        for (int k = 0; k < cnt; k++) px[k] = raw_pixels[i + k];
        if (i == 0) put_beat(1'b1, {1'b0, 7'(total - 1)}, cnt, px);
        else put_beat(1'b0, '0, cnt, px);
      end
      raw_pixels.delete();
    endfunction

    function void add_raw(px_t p);
      raw_pixels.push_back(p);
      if (raw_pixels.size() >= MAX_PACKET_PIXELS) flush_raw();
    endfunction

    function void emit_run();
      px_t px[4];
      px    = '{default: '0};
      px[0] = run_pixel;
      put_beat(1'b1, REPEAT_FLAG | {1'b0, 7'(run_len - 1)}, 1, px);
      run_len  = 0;
      enc_mode = MODE_IDLE;
    endfunction

    function void take_fresh(px_t x, bit is_last);
      if (is_last) begin
        add_raw(x);
        flush_raw();
        enc_mode = MODE_IDLE;
      end else begin
        lookahead = x;
        enc_mode  = MODE_PEND;
      end
    endfunction

    // Advance the encoder by one accepted pixel and queue the beats it causes.
    function void note_pixel(px_t x, bit is_last);
      px_t m;
      m = lane_mask();
      burst_beats.delete();
      case (enc_mode)
        MODE_PEND: begin
          if ((x & m) == (lookahead & m)) begin
            flush_raw();
            run_pixel = lookahead;
            run_len   = 2;
            enc_mode  = MODE_RUN;
            if (run_len >= MAX_PACKET_PIXELS || is_last) emit_run();
          end else begin
            add_raw(lookahead);
            take_fresh(x, is_last);
          end
        end
        MODE_RUN: begin
          if ((x & m) == (run_pixel & m)) begin
            run_len++;
            if (run_len >= MAX_PACKET_PIXELS || is_last) emit_run();
          end else begin
            emit_run();
            take_fresh(x, is_last);
          end
        end
        default: begin
          enc_mode = MODE_IDLE;
          take_fresh(x, is_last);
        end
      endcase
      if (burst_beats.size() > 0) burst_beats[$].burst_end = 1'b1;
      foreach (burst_beats[i]) expected_beats.push_back(burst_beats[i]);
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_SHOWN) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_beat(beat_t got);
      beat_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected beat %h", got));
        return;
      end
      want = expected_beats.pop_front();
      if (got.hdr_valid !== want.hdr_valid)
        report($sformatf("header_present %b, want %b", got.hdr_valid, want.hdr_valid));
      if (got.hdr !== want.hdr)
        report($sformatf("header_byte %h, want %h", got.hdr, want.hdr));
      if (got.npix !== want.npix)
        report($sformatf("pixels_in_item %0d, want %0d", got.npix, want.npix));
      if (got.lanes_lo !== want.lanes_lo)
        report($sformatf("pixel_pair_first %h, want %h", got.lanes_lo, want.lanes_lo));
      if (got.lanes_hi !== want.lanes_hi)
        report($sformatf("pixel_pair_second %h, want %h", got.lanes_hi, want.lanes_hi));
      if (got.burst_end !== want.burst_end)
        report($sformatf("final_of_burst %b, want %b", got.burst_end, want.burst_end));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [BPP_W-1:0] cfg_wdata_i;

  trle_pix_if pix ();
  trle_pkt_if pkt ();

  targa_rle_packet_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix),
    .pkt_o       (pkt)
  );

  rle_packet_scoreboard sb = new();

  // Pixels of the image being built, sent in order by send_image.
  px_t image_q[$];
  int  burst_left = 0;
  int  pixels_sent = 0;
  bit  pressure_go = 1'b0;

  // 8 ns clock: high and low halves of 4 ns each.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs or loses beats.
  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Collect every accepted output beat. Values read here are the ones that
  // were present just before the edge, since all drivers update via NBAs.
  always @(posedge clk_i) begin
    if (rst_ni && pkt.valid && pkt.ready) begin
      sb.check_beat('{pkt.header_present, pkt.header_byte, pkt.pixels_in_item,
                      pkt.pixel_pair_first, pkt.pixel_pair_second,
                      pkt.final_of_burst});
    end
  end

  // Receiver: switch at random between stall patterns, and once, as
  // soon as the random part begins, hold off for a long stretch so the
  // output register fills and the block back-pressures the pixel input.
  initial begin
    rx_pattern_e pattern;
    int          cyc;
    int          hold_left;
    int          stall_left;
    bit          hold_done;
    pattern    = RX_OPEN;
    cyc        = 0;
    hold_left  = 0;
    stall_left = 0;
    hold_done  = 1'b0;
    pkt.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        pkt.ready <= 1'b0;
      end else if (pressure_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        pkt.ready <= 1'b0;
      end else begin
        if (cyc % 64 == 0) pattern = rx_pattern_e'($urandom_range(0, 3));
        case (pattern)
          RX_OPEN:      pkt.ready <= 1'b1;
          RX_ALTERNATE: pkt.ready <= cyc[0];
          RX_COIN:      pkt.ready <= 1'($urandom_range(0, 1));
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              pkt.ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
              stall_left = $urandom_range(1, 6);
              pkt.ready <= 1'b0;
            end else begin
              pkt.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Offer one pixel and hold it until it is taken. Bursts of random length
  // are separated by random gaps; valid stays high across a burst.
  task automatic send_pixel(px_t value, bit is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    pix.valid       <= 1'b1;
    pix.pixel_value <= value;
    pix.last_pixel  <= is_last;
    do @(posedge clk_i); while (!pix.ready);
    sb.note_pixel(value, is_last);
    burst_left--;
    pixels_sent++;
  endtask

  // Send the pixels built so far; flag the final one with last_pixel if asked.
  task automatic send_image(bit with_last);
    foreach (image_q[i]) send_pixel(image_q[i], with_last && (i == image_q.size() - 1));
    image_q.delete();
  endtask

  // Drop valid and wait until every expected beat has left the block.
  task automatic drain();
    pix.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the byte count register with the block idle.
  task automatic write_bpp(logic [BPP_W-1:0] value);
    drain();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.bpp = value;
  endtask

  // Randomise the bytes that the current byte count ignores.
  function automatic px_t dress(px_t value);
    px_t m;
    m = sb.lane_mask();
    return (value & m) | (px_t'($urandom) & ~m);
  endfunction

  function automatic void push_run(px_t value, int len);
    repeat (len) image_q.push_back(dress(value));
  endfunction

  // Pixels that each differ from their predecessor in the active bytes.
  function automatic void push_raw(int len);
    px_t p;
    px_t m;
    m = sb.lane_mask();
    repeat (len) begin
      do p = $urandom; while (image_q.size() > 0 && ((p ^ image_q[$]) & m) == '0);
      image_q.push_back(p);
    end
  endfunction

  initial begin
    px_t palette[3];
    int  phase;
    int  len;
    int  roll;
    bit  long_run_done;
    bit  long_raw_done;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= BPP_RESET;
    pix.valid       <= 1'b0;
    pix.pixel_value <= '0;
    pix.last_pixel  <= 1'b0;
    long_run_done = 1'b0;
    long_raw_done = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset byte count of four: single-pixel image, a run of
    // two ended by last_pixel, then raw pixels broken by a run of three.
    image_q = '{32'h0000_0000};
    send_image(1'b1);
    image_q = '{32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_image(1'b1);
    image_q = '{32'h1, 32'h2, 32'h3, 32'h3, 32'h3, 32'h4};
    send_image(1'b1);

    // Byte count 0 acts as 1: only the low byte decides and is sent.
    write_bpp(3'd0);
    image_q = '{32'hAABB_CC11, 32'h0000_0011, 32'h1234_5612};
    send_image(1'b1);

    // Byte count above 4 acts as 4: a difference in the top bit still counts.
    write_bpp(3'd7);
    image_q = '{32'h1234_5678, 32'h9234_5678};
    send_image(1'b1);

    // Two bytes: a run whose pixels differ only in the ignored bytes.
    write_bpp(3'd2);
    image_q = '{32'h0000_BEEF, 32'hFFFF_BEEF, 32'h1234_BEEF};
    send_image(1'b1);

    // Three bytes: a raw packet of five, spread over two beats.
    write_bpp(3'd3);
    image_q = '{32'h0100_0001, 32'h0200_0002, 32'hFF00_0003, 32'h0000_0004,
                32'hFFFF_FFFF};
    send_image(1'b1);

    // Byte count changed mid-image: the lookahead pixel keeps all its bytes
    // and is judged under the new count.
    write_bpp(3'd1);
    image_q = '{32'h1122_3344};
    send_image(1'b0);
    write_bpp(3'd4);
    image_q = '{32'h9922_3344};
    send_image(1'b1);

    // Random part: phases of images under a fresh byte count each. Images are
    // mostly runs and raw stretches with random content, plus palette noise;
    // one holds a run past the packet limit and one a raw stretch past it.
    pixels_sent = 0;
    phase = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      case (phase)
        0:       write_bpp(3'd7);
        1:       write_bpp(3'd0);
        default: write_bpp(BPP_W'($urandom_range(0, 7)));
      endcase
      pressure_go = 1'b1;
      repeat ($urandom_range(2, 5)) begin
        foreach (palette[k]) begin
          roll = $urandom_range(0, 5);
          palette[k] = (roll == 0) ? '0 : (roll == 1) ? '1 : px_t'($urandom);
        end
        len = $urandom_range(1, 30);
        while (image_q.size() < len) begin
          roll = $urandom_range(0, 9);
          if (roll < 4) begin
            push_run(($urandom_range(0, 1) == 0) ? palette[$urandom_range(0, 2)]
                                                 : px_t'($urandom),
                     $urandom_range(2, 6));
          end else if (roll < 7) begin
            push_raw($urandom_range(1, 6));
          end else begin
            image_q.push_back(dress(palette[$urandom_range(0, 2)]));
          end
        end
        if (phase == 1 && !long_run_done) begin
          push_run($urandom, MAX_PACKET_PIXELS + 2);
          long_run_done = 1'b1;
        end
        if (phase == 2 && !long_raw_done) begin
          push_raw(MAX_PACKET_PIXELS + 3);
          long_raw_done = 1'b1;
        end
        // Now and then an image runs on into the next without last_pixel.
        send_image($urandom_range(0, 7) != 0);
      end
      phase++;
    end

    drain();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
